// ----- rtl/stsum_pkg.sv -----
// Shared types and constants of the segment tree range sum block.
`timescale 1ns / 1ps

package stsum_pkg;

    // Field widths of the stream words
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 16;
    localparam int TOTAL_W  = 26;
    localparam int COUNT_W  = 11;

    // Packed stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    localparam int DEFAULT_MAX_LEAVES = 1024;
    localparam int RESET_COUNT_CAP    = 1024;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_READ,
        ST_LD_WRITE,
        ST_Q_LO,
        ST_Q_HI,
        ST_Q_OUT
    } seq_state_t;

    typedef struct packed {
        logic                      init;
        logic                      add;
        logic signed [TOTAL_W-1:0] init_val;
    } acc_ctrl_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic error;
    } seq_status_t;

endpackage

// ----- rtl/segment_tree_range_sum.sv -----
// Top level of the segment tree range sum block: stream ports, count register, result register.
`timescale 1ns / 1ps

// Segment tree over signed 16-bit elements held in one node memory of
// 2*MAX_LEAVES partial sums, 26 bits each. A load word (tuser = 0) writes one
// element and walks its leaf-to-root path one level at a time, through the
// states LD_READ and LD_WRITE: read the sibling, add it in the shared adder,
// write the parent. A load at or beyond element_count is dropped. A query word
// (tuser = 1) walks the range bounds upward through the states Q_LO and Q_HI,
// with at most two node reads a level, and ends in Q_OUT; an out-of-count or
// empty range goes straight to Q_OUT. Every level goes through the single
// read port of the node memory and the one adder. The block takes one word at
// a time: it drops s_axis_tready from acceptance until the walk is done. A
// query result sits in an output register, so the next word is accepted while
// it waits. After reset a clearing pass writes zero to every node, with
// s_axis_tready low; cfg writes are taken at any time and must only be issued
// while the block is idle. element_count resets to min(1024, MAX_LEAVES); a
// write of 0 counts as 1, one above MAX_LEAVES as MAX_LEAVES.
module segment_tree_range_sum #(
    parameter int MAX_LEAVES = stsum_pkg::DEFAULT_MAX_LEAVES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // element_count write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [stsum_pkg::COUNT_W-1:0]    cfg_data,
    // command words
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // elem_index[9:0], elem_value[25:10], range_left[35:26], range_right[45:36], zero pad
    input  logic [stsum_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                             s_axis_tuser,
    // result words
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // range_total[25:0], zero pad
    output logic [stsum_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // range_error[0]
    output logic                             m_axis_tuser
);
    import stsum_pkg::*;

    localparam int AW = $clog2(2 * MAX_LEAVES);

    localparam logic [COUNT_W-1:0] RESET_COUNT =
        COUNT_W'((MAX_LEAVES < RESET_COUNT_CAP) ? MAX_LEAVES : RESET_COUNT_CAP);
    localparam logic [COUNT_W-1:0] MAX_COUNT =
        COUNT_W'((MAX_LEAVES < (2 ** COUNT_W)) ? MAX_LEAVES : (2 ** COUNT_W) - 1);

    // Unpacked command word
    cmd_t                      cmd;
    logic [INDEX_W-1:0]        elem_index;
    logic [VALUE_W-1:0]        elem_value;
    logic [INDEX_W-1:0]        range_left;
    logic [INDEX_W-1:0]        range_right;

    logic [COUNT_W-1:0]        count_reg, count_next;

    logic                      out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]        out_total_reg;
    logic                      out_error_reg;
    logic                      out_free;

    logic                      mem_wen;
    logic [AW-1:0]             mem_waddr;
    logic [TOTAL_W-1:0]        mem_wdata;
    logic                      mem_ren;
    logic [AW-1:0]             mem_raddr;
    logic [TOTAL_W-1:0]        mem_rdata;

    acc_ctrl_t                 acc_ctrl;
    logic signed [TOTAL_W-1:0] acc;
    logic signed [TOTAL_W-1:0] acc_sum;
    seq_status_t               status;

    assign cmd         = cmd_t'(s_axis_tuser);
    assign elem_index  = s_axis_tdata[9:0];
    assign elem_value  = s_axis_tdata[25:10];
    assign range_left  = s_axis_tdata[35:26];
    assign range_right = s_axis_tdata[45:36];

    // Element count register, clamped to 1 .. MAX_LEAVES on write
    assign cfg_ready = 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (cfg_valid)
        begin
            priority if (cfg_data == '0)
            begin
                count_next = COUNT_W'(1);
            end
            else if (32'(cfg_data) > MAX_LEAVES)
            begin
                count_next = MAX_COUNT;
            end
            else
            begin
                count_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RESET_COUNT;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            out_total_reg <= acc;
            out_error_reg <= status.error;
        end
    end

    assign s_axis_tready = status.ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - TOTAL_W){1'b0}}, out_total_reg};
    assign m_axis_tuser  = out_error_reg;

    stsum_seq #(
        .MAX_LEAVES (MAX_LEAVES),
        .AW         (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .cmd         (cmd),
        .elem_index  (elem_index),
        .elem_value  (elem_value),
        .range_left  (range_left),
        .range_right (range_right),
        .count       (count_reg),
        .out_free    (out_free),
        .acc_sum     (acc_sum),
        .mem_wen     (mem_wen),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_ren     (mem_ren),
        .mem_raddr   (mem_raddr),
        .acc_ctrl    (acc_ctrl),
        .status      (status)
    );

    stsum_node_mem #(
        .MAX_LEAVES (MAX_LEAVES),
        .AW         (AW)
    ) u_node_mem (
        .clk   (clk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    stsum_accum u_accum (
        .clk   (clk),
        .ctrl  (acc_ctrl),
        .rdata (mem_rdata),
        .acc   (acc),
        .sum   (acc_sum)
    );

endmodule

// ----- rtl/stsum_node_mem.sv -----
// Node sum memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module stsum_node_mem #(
    parameter int MAX_LEAVES = stsum_pkg::DEFAULT_MAX_LEAVES,
    parameter int AW         = $clog2(2 * MAX_LEAVES)
) (
    input  logic                             clk,
    input  logic                             wen,
    input  logic [AW-1:0]                    waddr,
    input  logic [stsum_pkg::TOTAL_W-1:0]    wdata,
    input  logic                             ren,
    input  logic [AW-1:0]                    raddr,
    output logic [stsum_pkg::TOTAL_W-1:0]    rdata
);
    import stsum_pkg::*;

    localparam int DEPTH = 2 * MAX_LEAVES;

    logic [TOTAL_W-1:0] mem [DEPTH];
    logic [TOTAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/stsum_accum.sv -----
// Shared adder with its accumulator register.
`timescale 1ns / 1ps

module stsum_accum (
    input  logic                                 clk,
    input  stsum_pkg::acc_ctrl_t                 ctrl,
    input  logic        [stsum_pkg::TOTAL_W-1:0] rdata,
    output logic signed [stsum_pkg::TOTAL_W-1:0] acc,
    output logic signed [stsum_pkg::TOTAL_W-1:0] sum
);
    import stsum_pkg::*;

    logic signed [TOTAL_W-1:0] acc_reg;
    logic signed [TOTAL_W-1:0] acc_next;

    // Sum wraps to the node width, matching the stored partial sums
    assign sum = acc_reg + $signed(rdata);

    always_comb
    begin
        priority if (ctrl.init)
        begin
            acc_next = ctrl.init_val;
        end
        else if (ctrl.add)
        begin
            acc_next = sum;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/stsum_seq.sv -----
// Sequencer: clearing pass, leaf-to-root update walk and range query walk.
`timescale 1ns / 1ps

module stsum_seq #(
    parameter int MAX_LEAVES = stsum_pkg::DEFAULT_MAX_LEAVES,
    parameter int AW         = $clog2(2 * MAX_LEAVES)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  stsum_pkg::cmd_t                      cmd,
    input  logic        [stsum_pkg::INDEX_W-1:0] elem_index,
    input  logic        [stsum_pkg::VALUE_W-1:0] elem_value,
    input  logic        [stsum_pkg::INDEX_W-1:0] range_left,
    input  logic        [stsum_pkg::INDEX_W-1:0] range_right,
    input  logic        [stsum_pkg::COUNT_W-1:0] count,
    input  logic                                 out_free,
    input  logic signed [stsum_pkg::TOTAL_W-1:0] acc_sum,
    output logic                                 mem_wen,
    output logic        [AW-1:0]                 mem_waddr,
    output logic        [stsum_pkg::TOTAL_W-1:0] mem_wdata,
    output logic                                 mem_ren,
    output logic        [AW-1:0]                 mem_raddr,
    output stsum_pkg::acc_ctrl_t                 acc_ctrl,
    output stsum_pkg::seq_status_t               status
);
    import stsum_pkg::*;

    localparam int DEPTH = 2 * MAX_LEAVES;
    localparam int PW    = $clog2(2 * MAX_LEAVES + 1);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [PW-1:0] LEAF_BASE = PW'(MAX_LEAVES);
    localparam logic [PW-1:0] PTR_ONE   = PW'(1);

    seq_state_t    state_reg, state_next;
    logic [PW-1:0] lo_reg, lo_next;
    logic [PW-1:0] hi_reg, hi_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          pend_reg, pend_next;
    logic          err_reg, err_next;

    logic                      accept;
    logic                      load_ok;
    logic                      range_bad;
    logic                      range_empty;
    logic signed [TOTAL_W-1:0] value_ext;
    logic [PW-1:0]             leaf_ptr;
    logic [PW-1:0]             hi_dec;

    assign accept      = (state_reg == ST_IDLE) && in_valid;
    assign load_ok     = {1'b0, elem_index} < count;
    assign range_bad   = ({1'b0, range_left} >= count) || ({1'b0, range_right} >= count);
    assign range_empty = range_right < range_left;
    assign value_ext   = {{(TOTAL_W - VALUE_W){elem_value[VALUE_W-1]}}, elem_value};
    assign leaf_ptr    = LEAF_BASE + PW'(elem_index);
    assign hi_dec      = hi_reg - PTR_ONE;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd == CMD_QUERY)
                    begin
                        state_next = (range_bad || range_empty) ? ST_Q_OUT : ST_Q_LO;
                    end
                    else if (load_ok)
                    begin
                        state_next = ST_LD_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LD_READ:
            begin
                state_next = (lo_reg <= PTR_ONE) ? ST_IDLE : ST_LD_WRITE;
            end
            ST_LD_WRITE:
            begin
                state_next = ST_LD_READ;
            end
            ST_Q_LO:
            begin
                state_next = (lo_reg >= hi_reg) ? ST_Q_OUT : ST_Q_HI;
            end
            ST_Q_HI:
            begin
                state_next = ST_Q_LO;
            end
            ST_Q_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath registers
    always_comb
    begin
        mem_wen           = 1'b0;
        mem_waddr         = AW'(lo_reg >> 1);
        mem_wdata         = acc_sum;
        mem_ren           = 1'b0;
        mem_raddr         = AW'(lo_reg);
        acc_ctrl.init     = 1'b0;
        acc_ctrl.add      = 1'b0;
        acc_ctrl.init_val = '0;
        status.ready      = 1'b0;
        status.done       = 1'b0;
        status.error      = err_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        clr_next          = clr_reg;
        pend_next         = 1'b0;
        err_next          = err_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wen   = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                status.ready = 1'b1;
                if (accept)
                begin
                    if (cmd == CMD_QUERY)
                    begin
                        acc_ctrl.init = 1'b1;
                        err_next      = range_bad;
                        lo_next       = LEAF_BASE + PW'(range_left);
                        hi_next       = LEAF_BASE + PW'(range_right) + PTR_ONE;
                    end
                    else if (load_ok)
                    begin
                        // Write the leaf and seed the walk with its value
                        mem_wen           = 1'b1;
                        mem_waddr         = AW'(leaf_ptr);
                        mem_wdata         = value_ext;
                        acc_ctrl.init     = 1'b1;
                        acc_ctrl.init_val = value_ext;
                        lo_next           = leaf_ptr;
                    end
                end
            end
            ST_LD_READ:
            begin
                // Fetch the sibling of the node on the path
                if (lo_reg > PTR_ONE)
                begin
                    mem_ren   = 1'b1;
                    mem_raddr = AW'(lo_reg ^ PTR_ONE);
                end
            end
            ST_LD_WRITE:
            begin
                acc_ctrl.add = 1'b1;
                mem_wen      = 1'b1;
                mem_waddr    = AW'(lo_reg >> 1);
                mem_wdata    = acc_sum;
                lo_next      = lo_reg >> 1;
            end
            ST_Q_LO:
            begin
                acc_ctrl.add = pend_reg;
                if ((lo_reg < hi_reg) && lo_reg[0])
                begin
                    mem_ren   = 1'b1;
                    mem_raddr = AW'(lo_reg);
                    pend_next = 1'b1;
                    lo_next   = lo_reg + PTR_ONE;
                end
            end
            ST_Q_HI:
            begin
                acc_ctrl.add = pend_reg;
                if (hi_reg[0])
                begin
                    mem_ren   = 1'b1;
                    mem_raddr = AW'(hi_dec);
                    pend_next = 1'b1;
                end
                lo_next = lo_reg >> 1;
                hi_next = hi_reg >> 1;
            end
            ST_Q_OUT:
            begin
                status.done = out_free;
            end
            default:
            begin
                mem_wen = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule
